/* rtl/frmma_pkg.sv */
`timescale 1ns / 1ps
// Package for the frame rate meter: field widths, constants and the
// command/status structs between controller and datapath. No dependencies.
package frmma_pkg;

    localparam int TS_W       = 32;
    localparam int RATE_W     = 28;
    localparam int TPS_W      = 30;
    localparam int FRAC_W     = 8;
    localparam int DIVD_W     = TPS_W + FRAC_W;
    localparam int DIVS_W     = TS_W;
    localparam int WINDOW_DEF = 16;

    localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(1000000);
    localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};

    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic latch_in;
        logic decide;
        logic update;
        logic start_avg;
        logic load_avg;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic measure;
        logic avg_needed;
        logic div_done;
        logic avg_done;
    } t_dp_stat;

endpackage

/* rtl/frmma_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
// Depends on frmma_pkg.
interface frmma_in_if import frmma_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            command;
    logic [TS_W-1:0] timestamp;

    modport source (output valid, output command, output timestamp, input ready);
    modport sink   (input valid, input command, input timestamp, output ready);
endinterface

interface frmma_out_if import frmma_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] current_rate;
    logic [RATE_W-1:0] average_rate;
    logic              time_went_back;
    logic              average_ready;

    modport source (output valid, output current_rate, output average_rate,
                    output time_went_back, output average_ready, input ready);
    modport sink   (input valid, input current_rate, input average_rate,
                    input time_went_back, input average_ready, output ready);
endinterface

/* rtl/frmma_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frmma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* rtl/frmma_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, used for the rate.
// Depends on frmma_pkg.
module frmma_div import frmma_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVS_W-1:0] r_dsr;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W:0]   rem_sh;
    logic              ge;

    assign rem_sh = {r_rem, r_quo[DIVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? DIVS_W'(rem_sh - {1'b0, r_dsr}) : rem_sh[DIVS_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

/* rtl/frmma_datapath.sv */
`timescale 1ns / 1ps
// Datapath: timestamp store, rate window RAM, running sum, divider, average and results.
// Depends on frmma_pkg, frmma_ram and frmma_div.
module frmma_datapath import frmma_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_cfg_wr_en,
    input  logic [TPS_W-1:0]  i_cfg_wr_data,
    input  logic              i_command,
    input  logic [TS_W-1:0]   i_timestamp,
    output logic [RATE_W-1:0] o_current_rate,
    output logic [RATE_W-1:0] o_average_rate,
    output logic              o_time_went_back,
    output logic              o_average_ready
);
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int COUNT_W = $clog2(WINDOW + 2);
    localparam int SUM_W   = RATE_W + SLOT_W;

    // sum / WINDOW as sum * ceil(2^RECIP_SH / WINDOW) >> RECIP_SH, one 8-bit digit per cycle
    localparam int AVG_CH    = 8;
    localparam int AVG_STEPS = (SUM_W + AVG_CH - 1) / AVG_CH;
    localparam int AVG_PAD   = AVG_STEPS * AVG_CH;
    localparam int AVG_CNT_W = $clog2(AVG_STEPS + 1);
    localparam int RECIP_SH  = RATE_W + 2 * SLOT_W;
    localparam int RECIP_W   = RATE_W + SLOT_W + 2;
    localparam int PROD_W    = AVG_PAD + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic [TPS_W-1:0]   r_tps;
    logic               r_command;
    logic [TS_W-1:0]    r_now;
    logic [TS_W-1:0]    r_prev;
    logic [SLOT_W-1:0]  r_slot;
    logic [COUNT_W-1:0] r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [RATE_W-1:0]  r_current;
    logic [RATE_W-1:0]  r_average;
    logic               r_went_back;
    logic [RATE_W-1:0]  r_out_current;
    logic [RATE_W-1:0]  r_out_average;
    logic               r_out_back;
    logic               r_out_avg_rdy;
    logic [AVG_CNT_W-1:0] r_avg_cnt;
    logic               r_avg_done;
    logic [AVG_PAD-1:0] r_avg_sh;
    logic [PROD_W-1:0]  r_avg_acc;

    logic               has_prev;
    logic               back;
    logic               measure;
    logic               full;
    logic               div_start;
    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    logic               div_done;
    logic [DIVD_W-1:0]  div_quo;
    logic [RATE_W-1:0]  ram_rd;
    logic [RATE_W-1:0]  old_rate;
    logic [RATE_W-1:0]  rate;
    logic [SUM_W-1:0]   n_sum;
    logic [SLOT_W-1:0]  n_slot;
    logic [AVG_CH-1:0]  avg_digit;
    logic [RECIP_W+AVG_CH-1:0] avg_part;
    logic [PROD_W-1:0]  n_avg_acc;

    assign has_prev = r_prev != '0;
    assign back     = has_prev && (r_prev > r_now);
    assign measure  = (r_command == CMD_SAMPLE) && has_prev && !back;
    assign full     = r_count >= COUNT_W'(WINDOW);

    assign div_start    = i_cmd.decide && measure;
    assign div_dividend = {r_tps, FRAC_W'(0)};
    assign div_divisor  = r_now - r_prev;

    frmma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Zero delta gives an all-ones quotient and saturates here as well.
    assign rate     = (div_quo[DIVD_W-1:RATE_W] != '0) ? RATE_MAX : div_quo[RATE_W-1:0];
    // Slots at or past the fill count were not written since the last clear.
    assign old_rate = full ? ram_rd : '0;
    assign n_sum    = r_sum - SUM_W'(old_rate) + SUM_W'(rate);
    assign n_slot   = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;

    assign avg_digit = r_avg_sh[AVG_PAD-1 -: AVG_CH];
    assign avg_part  = {AVG_CH'(0), RECIP} * {RECIP_W'(0), avg_digit};
    assign n_avg_acc = {r_avg_acc[PROD_W-AVG_CH-1:0], AVG_CH'(0)} + PROD_W'(avg_part);

    frmma_ram #(
        .WIDTH (RATE_W),
        .DEPTH (WINDOW)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.update),
        .i_wr_addr (r_slot),
        .i_wr_data (rate),
        .i_rd_en   (i_cmd.decide),
        .i_rd_addr (r_slot),
        .o_rd_data (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_command <= i_command;
            r_now     <= i_timestamp;
        end
        if (i_cmd.load_out) begin
            r_out_current <= r_current;
            r_out_average <= r_average;
            r_out_back    <= r_went_back;
            r_out_avg_rdy <= r_count > COUNT_W'(WINDOW);
        end
        if (i_cmd.start_avg) begin
            r_avg_sh  <= AVG_PAD'(r_sum);
            r_avg_acc <= '0;
        end else if (r_avg_cnt != '0) begin
            r_avg_sh  <= {r_avg_sh[AVG_PAD-AVG_CH-1:0], AVG_CH'(0)};
            r_avg_acc <= n_avg_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps       <= TPS_RESET;
            r_prev      <= '0;
            r_slot      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_current   <= '0;
            r_average   <= '0;
            r_went_back <= 1'b0;
            r_avg_cnt   <= '0;
            r_avg_done  <= 1'b0;
        end else begin
            r_avg_done <= 1'b0;
            if (i_cfg_wr_en) begin
                r_tps <= i_cfg_wr_data;
            end
            if (i_cmd.decide) begin
                r_went_back <= back && (r_command == CMD_SAMPLE);
                if ((r_command == CMD_RESTART) || back) begin
                    r_prev  <= '0;
                    r_slot  <= '0;
                    r_count <= '0;
                    r_sum   <= '0;
                end else if (!has_prev) begin
                    r_prev <= r_now;
                end
            end
            if (i_cmd.update) begin
                r_current <= rate;
                r_sum     <= n_sum;
                r_slot    <= n_slot;
                r_prev    <= r_now;
                if (r_count <= COUNT_W'(WINDOW)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.start_avg) begin
                r_avg_cnt <= AVG_CNT_W'(AVG_STEPS);
            end else if (r_avg_cnt != '0) begin
                r_avg_cnt <= r_avg_cnt - 1'b1;
                if (r_avg_cnt == AVG_CNT_W'(1)) begin
                    r_avg_done <= 1'b1;
                end
            end
            if (i_cmd.load_avg) begin
                r_average <= r_avg_acc[RECIP_SH +: RATE_W];
            end
        end
    end

    assign o_stat.measure    = measure;
    assign o_stat.avg_needed = full;
    assign o_stat.div_done   = div_done;
    assign o_stat.avg_done   = r_avg_done;

    assign o_current_rate   = r_out_current;
    assign o_average_rate   = r_out_average;
    assign o_time_went_back = r_out_back;
    assign o_average_ready  = r_out_avg_rdy;
endmodule

/* rtl/frmma_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: input/output handshakes and datapath sequencing.
// Depends on frmma_pkg.
module frmma_ctrl import frmma_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_RDIV   = 7'b0000100,
        S_UPD    = 7'b0001000,
        S_ASTART = 7'b0010000,
        S_ADIV   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_stat.measure ? S_RDIV : S_DONE;
            end
            S_RDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_stat.avg_needed ? S_ASTART : S_DONE;
            end
            S_ASTART: begin
                o_cmd.start_avg = 1'b1;
                n_state         = S_ADIV;
            end
            S_ADIV: begin
                if (i_stat.avg_done) begin
                    o_cmd.load_avg = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
endmodule

/* rtl/frame_rate_meter_moving_average.sv */
`timescale 1ns / 1ps
// Channel    Dir  Handshake      Payload
// i_in       in   valid/ready    command, timestamp
// o_out      out  valid/ready    current_rate, average_rate, time_went_back, average_ready
// i_cfg_*    in   write enable   ticks_per_second
// A restart, an earlier timestamp or a first timestamp skips the divider and goes to the result.
// A measurement runs the 38-step divider for the rate; one item is processed at a time.
// Once the window is full a reciprocal multiply (4 steps at the default window) follows it.
// Synchronous active-low reset; window RAM is not cleared, a fill count masks stale slots.
// A held result register lets the next item be taken while o_out stalls.
// Top level of the frame rate meter; depends on frmma_pkg, frmma_if, frmma_ctrl, frmma_datapath.
module frame_rate_meter_moving_average import frmma_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [TPS_W-1:0] i_cfg_wr_data,
    frmma_in_if.sink         i_in,
    frmma_out_if.source      o_out
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    frmma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    frmma_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_command        (i_in.command),
        .i_timestamp      (i_in.timestamp),
        .o_current_rate   (o_out.current_rate),
        .o_average_rate   (o_out.average_rate),
        .o_time_went_back (o_out.time_went_back),
        .o_average_ready  (o_out.average_ready)
    );
endmodule

/* rtl/frmma_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the frame rate meter, bound to the top level.
// Depends on frmma_pkg.
module frmma_checker import frmma_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [RATE_W-1:0] i_average_rate,
    input logic              i_time_went_back,
    input logic              i_average_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_average_rate))
        else $error("result item dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again before the item was processed");

    a_back_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_time_went_back |-> !i_average_ready)
        else $error("average ready after a clear");

    a_reset_idle: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");
endmodule

bind frame_rate_meter_moving_average frmma_checker u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_average_rate   (o_out.average_rate),
    .i_time_went_back (o_out.time_went_back),
    .i_average_ready  (o_out.average_ready)
);
